[hw/rtl/lsc_pkg.sv]
package lsc_pkg;

  localparam int unsigned LEVEL_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] RESET_ACTUAL = 16'h000B;
  localparam logic [LEVEL_W-1:0] RESET_LINEAR = 16'h0000;
  localparam logic [LEVEL_W-1:0] RESET_LAST   = 16'h00AA;
  localparam logic [LEVEL_W-1:0] RESET_LOW    = 16'h0001;
  localparam logic [LEVEL_W-1:0] RESET_HIGH   = 16'h7FFF;

  // one multiplier bit or one root digit (two radicand bits) per step
  localparam int unsigned ITER_N = LEVEL_W;
  localparam int unsigned ITER_W = $clog2(ITER_N);

  typedef enum logic [1:0] {
    FUNC_ACTUAL = 2'd0,
    FUNC_LINEAR = 2'd1,
    FUNC_RANGE  = 2'd2
  } func_t;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hw/rtl/lsc_if.sv]
interface lsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] value_a;
  logic [15:0] value_b;

  modport source (output valid, output func, output value_a, output value_b, input ready);
  modport sink (input valid, input func, input value_a, input value_b, output ready);
endinterface

interface lsc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] actual_level;
  logic [15:0] linear_level;
  logic [15:0] last_level;
  logic [15:0] min_level;
  logic [15:0] max_level;

  modport source (
    output valid, output status, output actual_level, output linear_level,
    output last_level, output min_level, output max_level, input ready
  );
  modport sink (
    input valid, input status, input actual_level, input linear_level,
    input last_level, input min_level, input max_level, output ready
  );
endinterface

[hw/rtl/lightness_state_converter.sv]
// channel  dir  port      payload
// -------  ---  --------  --------------------------------------------------------
// message  in   in_chan   func, value_a, value_b
// snapshot out  out_chan  status, actual_level, linear_level, last_level,
//                         min_level, max_level
//
// one message at a time; in_chan.ready is high only while idle
// actual set: the squarer works one multiplier bit per step, then a fold step, then the result beat
// linear set: the root unit works one root digit per step, then the result beat
// range set, rejected set or unused func: result beat on the next cycle
// synchronous active-low reset restores the power-up levels and range
// out_chan may stall freely; the snapshot holds until its beat is taken
module lightness_state_converter (
  input  logic          clk,
  input  logic          rst_n,
  lsc_in_if.sink        in_chan,
  lsc_out_if.source     out_chan
);

  localparam int unsigned W = lsc_pkg::LEVEL_W;

  lsc_pkg::ctl_state_t state_r;
  lsc_pkg::ctl_state_t state_nxt;

  // architectural lightness state
  logic [W-1:0] actual_r;
  logic [W-1:0] linear_r;
  logic [W-1:0] last_r;
  logic [W-1:0] low_r;
  logic [W-1:0] high_r;
  logic         status_r;

  logic in_beat;
  logic in_window;
  logic range_ok;
  logic is_set;
  logic set_ok;
  logic sqr_start;
  logic root_start;

  lsc_pkg::unit_stat_t sqr_stat;
  lsc_pkg::unit_stat_t root_stat;
  logic [W-1:0]        sqr_q;
  logic [W-1:0]        root_q;

  assign in_beat = in_chan.valid && in_chan.ready;

  // zero means off and is always allowed
  assign in_window = ((in_chan.value_a >= low_r) && (in_chan.value_a <= high_r))
                     || (in_chan.value_a == '0);
  assign range_ok  = (in_chan.value_a != '0) && (in_chan.value_b != '0)
                     && (in_chan.value_a <= in_chan.value_b);
  assign is_set    = (in_chan.func == lsc_pkg::FUNC_ACTUAL)
                     || (in_chan.func == lsc_pkg::FUNC_LINEAR);
  assign set_ok    = is_set && in_window;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsc_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = set_ok ? lsc_pkg::ST_RUN : lsc_pkg::ST_OUT;
        end
      end
      lsc_pkg::ST_RUN: begin
        if (sqr_stat.done || root_stat.done) begin
          state_nxt = lsc_pkg::ST_OUT;
        end
      end
      lsc_pkg::ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = lsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lsc_pkg::ST_IDLE;
    endcase
  end

  // handshake and unit launch
  always_comb begin
    in_chan.ready  = 1'b0;
    out_chan.valid = 1'b0;
    sqr_start      = 1'b0;
    root_start     = 1'b0;
    unique case (state_r)
      lsc_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        sqr_start     = in_chan.valid && set_ok
                        && (in_chan.func == lsc_pkg::FUNC_ACTUAL);
        root_start    = in_chan.valid && set_ok
                        && (in_chan.func == lsc_pkg::FUNC_LINEAR);
      end
      lsc_pkg::ST_RUN: begin
      end
      lsc_pkg::ST_OUT: begin
        out_chan.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      actual_r <= lsc_pkg::RESET_ACTUAL;
      linear_r <= lsc_pkg::RESET_LINEAR;
      last_r   <= lsc_pkg::RESET_LAST;
      low_r    <= lsc_pkg::RESET_LOW;
      high_r   <= lsc_pkg::RESET_HIGH;
      status_r <= lsc_pkg::STATUS_OK;
    end else begin
      if (in_beat) begin
        unique case (in_chan.func)
          lsc_pkg::FUNC_ACTUAL, lsc_pkg::FUNC_LINEAR: begin
            if (in_window) begin
              status_r <= lsc_pkg::STATUS_OK;
              // keep the old level as last unless it was off
              if (actual_r != '0) begin
                last_r <= actual_r;
              end
              if (in_chan.func == lsc_pkg::FUNC_ACTUAL) begin
                actual_r <= in_chan.value_a;
              end else begin
                linear_r <= in_chan.value_a;
              end
            end else begin
              status_r <= lsc_pkg::STATUS_REJECT;
            end
          end
          lsc_pkg::FUNC_RANGE: begin
            if (range_ok) begin
              status_r <= lsc_pkg::STATUS_OK;
              low_r    <= in_chan.value_a;
              high_r   <= in_chan.value_b;
            end else begin
              status_r <= lsc_pkg::STATUS_REJECT;
            end
          end
          default: status_r <= lsc_pkg::STATUS_OK;
        endcase
      end
      // derived level lands when its unit finishes
      if (sqr_stat.done) begin
        linear_r <= sqr_q;
      end
      if (root_stat.done) begin
        actual_r <= root_q;
      end
    end
  end

  lsc_square u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqr_start),
    .operand (in_chan.value_a),
    .stat    (sqr_stat),
    .result  (sqr_q)
  );

  lsc_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .operand (in_chan.value_a),
    .stat    (root_stat),
    .result  (root_q)
  );

  assign out_chan.status       = status_r;
  assign out_chan.actual_level = actual_r;
  assign out_chan.linear_level = linear_r;
  assign out_chan.last_level   = last_r;
  assign out_chan.min_level    = low_r;
  assign out_chan.max_level    = high_r;

  // a unit only finishes while the controller waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (sqr_stat.done || root_stat.done) |-> (state_r == lsc_pkg::ST_RUN))
    else $error("unit finished outside run state");

  // never both units at work
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqr_stat.busy && root_stat.busy))
    else $error("both arithmetic units busy");

  // a range message answers on the next cycle
  a_range_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_chan.func == lsc_pkg::FUNC_RANGE)) |=> out_chan.valid)
    else $error("range message did not answer at once");

  // the stored range stays well formed
  a_range_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((low_r != '0) && (low_r <= high_r)))
    else $error("stored range malformed");

endmodule

[hw/rtl/lsc_square.sv]
// shift-add squarer, one multiplier bit per cycle, then ceil(x / 65535)
module lsc_square (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsc_pkg::LEVEL_W-1:0]   operand,
  output lsc_pkg::unit_stat_t           stat,
  output logic [lsc_pkg::LEVEL_W-1:0]   result
);

  localparam int unsigned W = lsc_pkg::LEVEL_W;

  logic                         busy_r;
  logic                         fin_r;
  logic                         done_r;
  logic [lsc_pkg::ITER_W-1:0]   cnt_r;
  logic [W-1:0]                 mcand_r;
  logic [W-1:0]                 hi_r;
  logic [W-1:0]                 lo_r;
  logic [W-1:0]                 q_r;

  logic [W:0]   sum;
  logic [W-1:0] hi_nxt;
  logic [W-1:0] lo_nxt;
  logic [W:0]   lo_bias;
  logic [W:0]   h_part;
  logic [W+1:0] fold;
  logic [W:0]   q_nxt;

  always_comb begin
    sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    hi_nxt = sum[W:1];
    lo_nxt = {sum[0], lo_r[W-1:1]};
  end

  // x + 65534 split at bit 16; since 2^16 = 1 mod 65535, x / 65535 = h + (h + l) / 65535
  always_comb begin
    lo_bias = {1'b0, lo_r} + {1'b0, lsc_pkg::LEVEL_FULL - W'(1)};
    h_part  = {1'b0, hi_r} + {{W{1'b0}}, lo_bias[W]};
    fold    = {1'b0, h_part} + {2'b00, lo_bias[W-1:0]};
    priority if (fold >= {1'b0, lsc_pkg::LEVEL_FULL, 1'b0}) begin
      q_nxt = h_part + (W+1)'(2);
    end else if (fold >= {2'b00, lsc_pkg::LEVEL_FULL}) begin
      q_nxt = h_part + (W+1)'(1);
    end else begin
      q_nxt = h_part;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        done_r <= 1'b0;
        if (cnt_r == lsc_pkg::ITER_W'(lsc_pkg::ITER_N - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else begin
        // fold cycle flags done for one cycle
        fin_r  <= 1'b0;
        done_r <= fin_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= operand;
      hi_r    <= '0;
      lo_r    <= operand;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    if (fin_r) begin
      q_r <= q_nxt[W-1:0];
    end
  end

  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;
  assign result    = q_r;

endmodule

[hw/rtl/lsc_root.sv]
// restoring square root of l * 65535, one two-bit radicand digit per cycle
module lsc_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsc_pkg::LEVEL_W-1:0]   operand,
  output lsc_pkg::unit_stat_t           stat,
  output logic [lsc_pkg::LEVEL_W-1:0]   result
);

  localparam int unsigned W = lsc_pkg::LEVEL_W;

  logic                         busy_r;
  logic                         done_r;
  logic [lsc_pkg::ITER_W-1:0]   cnt_r;
  logic [2*W-1:0]               rad_r;
  logic [W-1:0]                 rem_r;
  logic [W-1:0]                 root_r;

  logic [2*W-1:0] rad_init;
  logic [W+1:0]   rem_shift;
  logic [W+1:0]   trial;
  logic [W+1:0]   diff;
  logic           fits;
  logic           last_digit;

  // l * 65535 = (l << 16) - l
  assign rad_init = {operand, {W{1'b0}}} - {{W{1'b0}}, operand};

  assign last_digit = (cnt_r == lsc_pkg::ITER_W'(lsc_pkg::ITER_N - 1));

  always_comb begin
    rem_shift = {rem_r, rad_r[2*W-1:2*W-2]};
    trial     = {root_r, 2'b01};
    fits      = rem_shift >= trial;
    diff      = rem_shift - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        done_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 1'b1;
        done_r <= last_digit;
        if (last_digit) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // remainder stays below 2^16 until the last digit, which is never reused
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad_init;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*W-3:0], 2'b00};
      rem_r  <= fits ? diff[W-1:0] : rem_shift[W-1:0];
      root_r <= {root_r[W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = root_r;

endmodule
